// ----- rtl/wsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, character codes and helpers for the wildcard stream matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

   localparam int PATTERN_DEPTH_DEFAULT = 64;
   localparam int RSP_QUEUE_DEPTH       = 3;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_END   = 8'h00;

   typedef enum logic [1:0] {
      KIND_PATTERN = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef struct packed {
      logic [5:0] cursor_position;
      logic       matched;
   } rsp_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic sensitive);
      logic [7:0] r;
      r = c;
      if (!sensitive && c >= CH_LOW_A && c <= CH_LOW_Z) begin
         r = CH_UP_A + (c - CH_LOW_A);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/wsm_pattern_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_pattern_mem
// Pattern store: one write port, two registered read ports, write bypass.
// ----------------------------------------------------------------------------
module wsm_pattern_mem
   import wsm_pkg::*;
#(
   parameter int DEPTH = PATTERN_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [7:0]    rd_data_a,
   output logic      [7:0]    rd_data_b
);

   logic [7:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_addr_a) begin
         rd_data_a <= wr_data;
      end else begin
         rd_data_a <= mem[rd_addr_a];
      end
      if (wr_en && wr_addr == rd_addr_b) begin
         rd_data_b <= wr_data;
      end else begin
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/wsm_cursor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_cursor_core
// Cursor and resume point update, pattern store addressing, result forming.
// ----------------------------------------------------------------------------
module wsm_cursor_core
   import wsm_pkg::*;
#(
   parameter int DEPTH = PATTERN_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire kind_type      kind,
   input  wire logic [7:0]    byte_value,
   input  wire logic [5:0]    pattern_index,
   input  wire logic          case_sensitive,
   input  wire logic [7:0]    rd_data_a,
   input  wire logic [7:0]    rd_data_b,
   output logic               wr_en,
   output logic      [AW-1:0] wr_addr,
   output logic      [7:0]    wr_data,
   output logic      [AW-1:0] rd_addr_a,
   output logic      [AW-1:0] rd_addr_b,
   output rsp_type            result
);

   localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] resume_ff, resume_in;
   logic          end_a_ff, end_a_in;
   logic          end_b_ff, end_b_in;
   logic [7:0]    c0, c1, c2;
   logic [CW:0]   plus1, plus2, cur_next, res_next, cur_adv;
   logic [AW+5:0] idx_ext;
   logic          idx_ok;
   logic [CW+5:0] pos_ext;

   assign idx_ext = {{AW{1'b0}}, pattern_index};
   assign idx_ok  = (AW + 6)'(DEPTH) > idx_ext;

   always_comb begin
      c0       = fold(byte_value, case_sensitive);
      c1       = end_a_ff ? CH_END : fold(rd_data_a, case_sensitive);
      c2       = end_b_ff ? CH_END : fold(rd_data_b, case_sensitive);
      plus1    = {1'b0, cursor_ff} + (CW + 1)'(1);
      plus2    = {1'b0, cursor_ff} + (CW + 1)'(2);
      cur_next = {1'b0, cursor_ff};
      res_next = {1'b0, resume_ff};
      wr_en    = 1'b0;
      if (accept) begin
         unique case (kind)
            KIND_PATTERN: begin
               wr_en = idx_ok;
            end
            KIND_DATA: begin
               if (c1 != CH_END) begin
                  if (c1 == CH_STAR) begin
                     if (c2 == CH_STAR) begin
                        cur_next = plus1;
                        res_next = plus1;
                     end else if (c0 == c2) begin
                        cur_next = (c2 == CH_END) ? plus1 : plus2;
                        res_next = cur_next;
                     end
                  end else if (c1 == CH_QUERY) begin
                     cur_next = plus1;
                     if (cursor_ff == resume_ff) begin
                        res_next = plus1;
                     end
                  end else if (c0 == c1) begin
                     cur_next = plus1;
                  end else begin
                     cur_next = {1'b0, resume_ff};
                  end
               end
            end
            KIND_RESTART: begin
               cur_next = '0;
               res_next = '0;
            end
            default: begin
            end
         endcase
      end
      if (cur_next > DEPTH_W) begin
         cur_next = DEPTH_W;
      end
      if (res_next > DEPTH_W) begin
         res_next = DEPTH_W;
      end
      cursor_in = cur_next[CW-1:0];
      resume_in = res_next[CW-1:0];
      cur_adv   = {1'b0, cursor_in} + (CW + 1)'(1);
      end_a_in  = {1'b0, cursor_in} >= DEPTH_W;
      end_b_in  = cur_adv >= DEPTH_W;
   end

   assign wr_addr   = idx_ext[AW-1:0];
   assign wr_data   = byte_value;
   assign rd_addr_a = cursor_in[AW-1:0];
   assign rd_addr_b = cur_adv[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         resume_ff <= '0;
         end_a_ff  <= 1'b0;
         end_b_ff  <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         resume_ff <= resume_in;
         end_a_ff  <= end_a_in;
         end_b_ff  <= end_b_in;
      end
   end

   assign pos_ext                = {6'b0, cursor_ff};
   assign result.cursor_position = pos_ext[5:0];
   assign result.matched         = end_a_ff || (rd_data_a == CH_END);

endmodule
`default_nettype wire

// ----- rtl/wsm_rsp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_rsp_queue
// Small result queue between the matcher and the response stream.
// ----------------------------------------------------------------------------
module wsm_rsp_queue
   import wsm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire rsp_type    push_data,
   input  wire logic       pop,
   output logic            out_valid,
   output rsp_type         out_data,
   output logic      [1:0] count
);

   localparam logic [1:0] LAST = 2'(RSP_QUEUE_DEPTH - 1);

   rsp_type    slot_ff [0:RSP_QUEUE_DEPTH-1];
   logic [1:0] wptr_ff, wptr_in;
   logic [1:0] rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == LAST) ? 2'd0 : wptr_ff + 2'd1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == LAST) ? 2'd0 : rptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// ----- rtl/wildcard_stream_matcher_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_stream_matcher_unit
// Byte-at-a-time wildcard pattern matcher with a writable pattern store.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_tready is high: pattern writes,
// data bytes and restarts may follow each other back to back. Each request
// gives one response from the registered store read at the new cursor, via
// the response queue. The cursor loop closes through the two-port pattern
// memory, which is addressed with the next cursor so the entries under the
// cursor are ready when the next byte comes. A three-entry response queue
// keeps the request side running while the response side stalls, until it
// is full. Pattern entries hold no value until written; the pattern must be
// written and zero-terminated before data bytes are sent.
// ----------------------------------------------------------------------------
module wildcard_stream_matcher_unit
   import wsm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // byte_value[7:0], pattern_index[13:8], zero
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,  // matched[0], cursor_position[6:1], zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   localparam int AW = $clog2(PATTERN_DEPTH);
   localparam int CW = $clog2(PATTERN_DEPTH + 1);

   logic          accept;
   kind_type      kind;
   logic          case_sensitive_ff, case_sensitive_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [7:0]    wr_data, rd_data_a, rd_data_b;
   rsp_type       result, q_data;
   logic [1:0]    q_count;
   logic          q_pop;

   assign accept    = req_tvalid && req_tready;
   assign kind      = kind_type'(req_tuser);
   assign csr_ready = 1'b1;

   assign case_sensitive_in = (csr_valid && csr_ready) ? csr_data : case_sensitive_ff;
   assign pend_valid_in     = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         case_sensitive_ff <= 1'b0;
         pend_valid_ff     <= 1'b0;
      end else begin
         case_sensitive_ff <= case_sensitive_in;
         pend_valid_ff     <= pend_valid_in;
      end
   end

   assign req_tready = ({1'b0, q_count} + {2'b0, pend_valid_ff}) < 3'(RSP_QUEUE_DEPTH);

   wsm_pattern_mem #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   wsm_cursor_core #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (kind),
      .byte_value     (req_tdata[7:0]),
      .pattern_index  (req_tdata[13:8]),
      .case_sensitive (case_sensitive_ff),
      .rd_data_a      (rd_data_a),
      .rd_data_b      (rd_data_b),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr_a      (rd_addr_a),
      .rd_addr_b      (rd_addr_b),
      .result         (result)
   );

   assign q_pop = rsp_tvalid && rsp_tready;

   wsm_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pend_valid_ff),
      .push_data (result),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_tdata = {1'b0, q_data};

   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_valid_ff)
      else $error("accepted request did not reach the pending stage");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == KIND_RESTART) |=> (result.cursor_position == 6'd0))
      else $error("restart did not clear the cursor");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (q_count != 2'(RSP_QUEUE_DEPTH) || q_pop))
      else $error("response queue overflow");

endmodule
`default_nettype wire

// ----- verif/tb_wildcard_stream_matcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_stream_matcher_unit
// Self-checking test of the wildcard stream matcher. The store is filled
// first, then directed tests cover the end of the store, each wildcard, the
// star before the terminator, case folding, the unused kind and restarts.
// Random phases load patterns and feed matching and noisy data bytes under
// several sender and receiver idle rates, with a long receiver hold-off. A
// local model of the cursor predicts every response, which is compared
// field by field in order.
// ----------------------------------------------------------------------------
module tb_wildcard_stream_matcher_unit;
   import wsm_pkg::*;

   localparam int         STORE_DEPTH  = 64;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         MAX_REPORTS  = 40;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // byte_value[7:0], pattern_index[13:8], zero
   logic [1:0]  req_tuser  = '0;  // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // matched[0], cursor_position[6:1], zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   wildcard_stream_matcher_unit #(
      .PATTERN_DEPTH (STORE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // matcher state as predicted
   logic [7:0] pattern_mem [STORE_DEPTH];
   int         cursor_now;
   int         resume_now;
   logic       case_exact;

   rsp_type    pending_rsp_q [$];
   logic [7:0] pattern_buf [STORE_DEPTH];
   int         req_idle_pct;
   int         rsp_stall_pct;
   int         hold_off_left;
   int         request_count;
   int         response_count;
   int         error_count;
   int         cycle_count;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (!case_exact && c >= CH_LOW_A && c <= CH_LOW_Z) begin
         return c - CH_LOW_A + CH_UP_A;
      end
      return c;
   endfunction

   function automatic logic [7:0] pattern_char(input int pos);
      if (pos >= STORE_DEPTH) begin
         return CH_END;
      end
      return upcase(pattern_mem[pos]);
   endfunction

   function automatic void step_cursor(input logic [7:0] value);
      logic [7:0] d;
      logic [7:0] here;
      logic [7:0] ahead;
      bit         at_resume;
      d    = upcase(value);
      here = pattern_char(cursor_now);
      if (here == CH_END) begin
         return;
      end
      ahead = pattern_char(cursor_now + 1);
      if (here == CH_STAR) begin
         if (ahead == CH_STAR) begin
            cursor_now = cursor_now + 1;
            resume_now = cursor_now;
         end else if (d == ahead) begin
            cursor_now = cursor_now + ((ahead == CH_END) ? 1 : 2);
            resume_now = cursor_now;
         end
      end else if (here == CH_QUERY) begin
         at_resume  = (cursor_now == resume_now);
         cursor_now = cursor_now + 1;
         if (at_resume) begin
            resume_now = cursor_now;
         end
      end else if (d == here) begin
         cursor_now = cursor_now + 1;
      end else begin
         cursor_now = resume_now;
      end
      if (cursor_now > STORE_DEPTH) begin
         cursor_now = STORE_DEPTH;
      end
      if (resume_now > STORE_DEPTH) begin
         resume_now = STORE_DEPTH;
      end
   endfunction

   function automatic rsp_type predict_match(input logic [1:0] kind, input logic [7:0] value,
                                             input logic [5:0] index);
      rsp_type r;
      case (kind)
         KIND_PATTERN: begin
            pattern_mem[index] = value;
         end
         KIND_DATA: begin
            step_cursor(value);
         end
         KIND_RESTART: begin
            cursor_now = 0;
            resume_now = 0;
         end
         default: begin
         end
      endcase
      r.matched         = (pattern_char(cursor_now) == CH_END);
      r.cursor_position = cursor_now[5:0];
      return r;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [7:0] value,
                               input logic [5:0] index);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, index, value};
      do @(posedge clock); while (!req_tready);
      pending_rsp_q.push_back(predict_match(kind, value, index));
      request_count++;
   endtask

   task automatic send_data(input logic [7:0] value);
      send_request(KIND_DATA, value, 6'($urandom_range(63)));
   endtask

   task automatic send_restart();
      send_request(KIND_RESTART, 8'($urandom_range(255)), 6'($urandom_range(63)));
   endtask

   task automatic load_pattern(input int len);
      for (int i = 0; i < len; i++) begin
         send_request(KIND_PATTERN, pattern_buf[i], 6'(i));
      end
      if (len < STORE_DEPTH) begin
         send_request(KIND_PATTERN, CH_END, 6'(len));
      end
   endtask

   task automatic load_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pattern_buf[i] = text[i];
      end
      load_pattern(text.len());
   endtask

   task automatic feed_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_data(text[i]);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_case_mode(input logic mode);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      case_exact = mode;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready    <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[6:0]);
         if (pending_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected response, expected none, actual %h", $time,
                        rsp_tdata);
            end
         end else begin
            want = pending_rsp_q.pop_front();
            response_count++;
            if (got.matched !== want.matched) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: matched mismatch, expected %0b, actual %0b", $time,
                           want.matched, got.matched);
               end
            end
            if (got.cursor_position !== want.cursor_position) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: cursor_position mismatch, expected %0d, actual %0d",
                           $time, want.cursor_position, got.cursor_position);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_rsp_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // "*A" repeated, no terminator anywhere in the store
   task automatic test_fill_store();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         pattern_buf[i] = (i % 2 == 0) ? CH_STAR : "A";
      end
      load_pattern(STORE_DEPTH);
   endtask

   task automatic test_end_of_store();
      send_restart();
      send_data("b");
      for (int i = 0; i < STORE_DEPTH / 2; i++) begin
         send_data("a");
      end
      send_data("Z");
   endtask

   task automatic test_wildcards();
      load_text("**b");
      send_restart();
      feed_text("xbbq");
      load_text("a?c");
      send_restart();
      feed_text("azxazc");
      send_data(8'hFF);
   endtask

   task automatic test_star_before_end();
      load_text("*");
      send_restart();
      send_data("q");
      send_data(CH_END);
      send_data(CH_END);
   endtask

   task automatic test_case_folding();
      load_text("aB");
      send_restart();
      feed_text("Ab");
      write_case_mode(1'b1);
      send_restart();
      feed_text("AbaB");
      write_case_mode(1'b0);
   endtask

   task automatic test_misc_kinds();
      load_text("ab?");
      send_restart();
      send_data("a");
      send_request(KIND_UNUSED, 8'hFF, 6'd63);
      send_request(KIND_PATTERN, 8'hFF, 6'd63);
      send_request(KIND_PATTERN, "x", 6'd1);
      send_data("x");
      send_data(8'h00);
      send_request(KIND_UNUSED, 8'h00, 6'd0);
      send_restart();
   endtask

   function automatic logic [7:0] pick_pattern_char();
      int r;
      r = $urandom_range(99);
      if (r < 20) return CH_STAR;
      if (r < 35) return CH_QUERY;
      if (r < 50) return "a";
      if (r < 62) return "A";
      if (r < 75) return "b";
      if (r < 85) return "B";
      if (r < 92) return "c";
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [7:0] pick_data_char(input int len);
      int r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (r < 55 && len > 0) begin
         c = pattern_buf[$urandom_range(len - 1)];
         if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(1)) c = c - 8'h20;
         else if (c >= CH_UP_A && c <= 8'h5A && $urandom_range(1)) c = c + 8'h20;
         return c;
      end
      if (r < 80) begin
         case ($urandom_range(4))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            default: return "c";
         endcase
      end
      if (r < 85) return CH_END;
      return 8'($urandom_range(255));
   endfunction

   task automatic run_episode();
      int len;
      int n;
      int r;
      len = ($urandom_range(19) == 0) ? $urandom_range(STORE_DEPTH, 30)
                                      : $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
         pattern_buf[i] = pick_pattern_char();
      end
      load_pattern(len);
      send_restart();
      n = (len < 12) ? 2 * len + 4 : len + 8;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 4) begin
            send_restart();
         end else if (r < 7) begin
            send_request(KIND_UNUSED, 8'($urandom_range(255)), 6'($urandom_range(63)));
         end else if (r < 10) begin
            send_request(KIND_PATTERN, 8'($urandom_range(255)), 6'($urandom_range(63)));
         end else begin
            send_data(pick_data_char(len));
         end
      end
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input logic mode, input int n_items);
      int start;
      write_case_mode(mode);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      start         = request_count;
      while (request_count - start < n_items) begin
         run_episode();
      end
   endtask

   task automatic test_backpressure();
      int start;
      wait_drained();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_off_left <= 300;
      start         = request_count;
      while (request_count - start < 40) begin
         run_episode();
      end
   endtask

   initial begin
      cursor_now     = 0;
      resume_now     = 0;
      case_exact     = 1'b0;
      req_idle_pct   = 0;
      rsp_stall_pct  = 0;
      hold_off_left  = 0;
      request_count  = 0;
      response_count = 0;
      error_count    = 0;
      cycle_count    = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         pattern_mem[i] = CH_END;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_fill_store();
      test_end_of_store();
      test_wildcards();
      test_star_before_end();
      test_case_folding();
      test_misc_kinds();
      test_random_phase(0, 0, 1'b1, 120);
      test_random_phase(50, 0, 1'b0, 120);
      test_random_phase(0, 50, 1'b1, 120);
      test_random_phase(9, 9, 1'b0, 120);
      test_backpressure();
      write_case_mode(1'b1);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests and checked %0d responses: wildcards, case folding,",
               request_count, response_count);
      $display("store end, restarts, unused kind, idle and stall phases, long hold-off.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
